### src/sitoa_pkg.sv
// sitoa_pkg: shared constants, types and the shift-add-3 step
// for the signed integer to decimal ascii converter
// no dependencies
package sitoa_pkg;

    localparam int VAL_W          = 32;
    localparam int NUM_DIGITS     = 10;
    localparam int DIGIT_W        = 4;
    localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
    localparam int DAB_STAGES     = 4;
    localparam int BITS_PER_STAGE = VAL_W / DAB_STAGES;
    localparam int IDX_W          = $clog2(NUM_DIGITS);
    localparam int CHAR_W         = 8;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  ASCII_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'h2D;
    localparam logic [DIGIT_W-1:0] DAB_LIMIT   = 4'd5;
    localparam logic [DIGIT_W-1:0] DAB_ADJUST  = 4'd3;

    // one pipeline stage of the binary to bcd conversion
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
        logic [VAL_W-1:0] mag;
    } t_stage;

    // BITS_PER_STAGE rounds of add-3 then shift left
    function automatic t_stage dabble_group(input t_stage s);
        t_stage r;
        r = s;
        for (int b = 0; b < BITS_PER_STAGE; b++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (r.bcd[d*DIGIT_W +: DIGIT_W] >= DAB_LIMIT) begin
                    r.bcd[d*DIGIT_W +: DIGIT_W] = r.bcd[d*DIGIT_W +: DIGIT_W] + DAB_ADJUST;
                end
            end
            r.bcd = {r.bcd[BCD_W-2:0], r.mag[VAL_W-1]};
            r.mag = {r.mag[VAL_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

### src/signed_int_to_decimal_ascii_top.sv
// signed_int_to_decimal_ascii_top: pipelined signed 32-bit to decimal text converter
// depends on sitoa_pkg (constants, stage type, shift-add-3 function)
// an accepted item passes stage 0, stages 1..4 and stage 5 before the serializer loads it
// throughput: one character per cycle on the output while i_stall is low;
// an item gives 1 to 11 characters (sign plus significant digits)
// the six-stage conversion pipeline takes a new item every cycle while it has room
// reset: synchronous active-low i_rst_n clears all valid bits and the serializer
module signed_int_to_decimal_ascii_top
    import sitoa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [VAL_W-1:0]  i_value,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CHAR_W-1:0] o_character,
    output logic              o_last
);

    // pipeline map
    //   stage 0      : sign and magnitude (one 32-bit negate)
    //   stages 1..4  : eight shift-add-3 rounds each
    //   stage 5      : index of the most significant nonzero digit
    //   serializer   : sign then digits, one character per cycle while i_stall is low
    localparam int LAST_STG = DAB_STAGES + 1;

    logic [LAST_STG:0]    r_vld;
    logic [LAST_STG:0]    en;
    t_stage               r_stg [0:DAB_STAGES];

    logic                 r_s5_neg;
    logic [BCD_W-1:0]     r_s5_bcd;
    logic [IDX_W-1:0]     r_s5_top;
    logic [IDX_W-1:0]     n_top;

    // serializer
    logic                 r_busy;
    logic                 r_neg_pend;
    logic [IDX_W-1:0]     r_idx;
    logic [BCD_W-1:0]     r_bcd;
    logic [DIGIT_W-1:0]   cur_digit;
    logic                 adv;
    logic                 fin;
    logic                 ld;

    logic                 in_neg;
    logic [VAL_W-1:0]     in_mag;

    // two's complement magnitude; the most negative value lands on 0x80000000
    assign in_neg = i_value[VAL_W-1];
    assign in_mag = in_neg ? (~i_value + {{(VAL_W-1){1'b0}}, 1'b1}) : i_value;

    // serializer handshake
    assign adv = r_busy && !i_stall;
    assign fin = !r_neg_pend && (r_idx == '0);
    assign ld  = r_vld[LAST_STG] && (!r_busy || (adv && fin));

    // a stage moves when it is empty or its successor moves
    always_comb begin
        en[LAST_STG] = !r_vld[LAST_STG] || ld;
        for (int k = LAST_STG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    // highest nonzero digit, zero when the whole value is zero
    always_comb begin
        n_top = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_stg[DAB_STAGES].bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
                n_top = IDX_W'(d);
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k <= LAST_STG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_stg[0].neg <= in_neg;
            r_stg[0].bcd <= '0;
            r_stg[0].mag <= in_mag;
        end
        for (int k = 1; k <= DAB_STAGES; k++) begin
            if (en[k]) begin
                r_stg[k] <= dabble_group(r_stg[k-1]);
            end
        end
        if (en[LAST_STG]) begin
            r_s5_neg <= r_stg[DAB_STAGES].neg;
            r_s5_bcd <= r_stg[DAB_STAGES].bcd;
            r_s5_top <= n_top;
        end
    end

    // serializer control: sign first, then digits down to index zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_neg_pend <= 1'b0;
            r_idx      <= '0;
        end else if (ld) begin
            r_busy     <= 1'b1;
            r_neg_pend <= r_s5_neg;
            r_idx      <= r_s5_top;
        end else if (adv) begin
            priority if (fin) begin
                r_busy <= 1'b0;
            end else if (r_neg_pend) begin
                r_neg_pend <= 1'b0;
            end else begin
                r_idx <= r_idx - IDX_W'(1);
            end
        end
    end

    // serializer digits
    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_bcd <= r_s5_bcd;
        end
    end

    assign cur_digit   = r_bcd[{r_idx, 2'b00} +: DIGIT_W];
    assign o_valid     = r_busy;
    assign o_character = r_neg_pend ? ASCII_MINUS
                                    : (ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit});
    assign o_last      = fin;

    // the sign is never the end of a number
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_character == ASCII_MINUS) |-> !o_last)
        else $error("minus sign marked last");

    // a number's characters come without a gap
    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid)
        else $error("character run broken");

    // only a minus or a decimal digit leaves the block
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == ASCII_MINUS) ||
                    ((o_character >= ASCII_ZERO) && (o_character <= ASCII_NINE)))
        else $error("character out of range");

    // the last pipeline stage holds its item while the serializer is busy
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST_STG] && !ld |=> r_vld[LAST_STG] && $stable(r_s5_bcd) && $stable(r_s5_top))
        else $error("stage 5 item lost under stall");

    // the leading digit of a number is never zero unless it is the only digit
    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld |=> (r_idx == '0) || (cur_digit != '0))
        else $error("leading zero digit");

endmodule

### tb/sv/tb_top.sv
// tb_top: self-checking testbench for signed_int_to_decimal_ascii_top
// depends on sitoa_pkg (widths and ascii codes) and the converter rtl
// predicts the decimal text of every accepted value and checks each character in order
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sitoa_pkg::*;

    // one expected character of the printed text
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    // generous bound: ~300 values, 11 chars each, heavy stalls, long hold-off
    localparam int CYCLE_LIMIT = 200000;
    // first character shows after the pipeline stages and the serializer, so a small margin covers it
    localparam int SETTLE_CYCLES = 20;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [VAL_W-1:0]  i_value;
    logic              o_valid;
    logic              i_stall;
    logic [CHAR_W-1:0] o_character;
    logic              o_last;

    // characters still owed by the converter, oldest first
    t_text_char pending_text[$];
    int         n_errors    = 0;
    int         cycle_count = 0;
    // idle and stall rates in percent, set per phase
    int         tx_idle_pct  = 0;
    int         rx_stall_pct = 0;
    // long receiver hold-off, counted down by the stall process
    int         hold_left    = 0;

    signed_int_to_decimal_ascii_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // receiver side: random stalls, or a solid hold-off while hold_left runs down
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // decimal text of one value: optional minus, then digits with leading zeros dropped
    function automatic void format_decimal(input logic [VAL_W-1:0] v);
        logic [VAL_W:0]   mag;
        logic [DIGIT_W-1:0] digs[NUM_DIGITS];
        int               n;
        t_text_char       c;
        // 33-bit magnitude so the most negative value needs no special case
        mag = v[VAL_W-1] ? ({1'b1, {VAL_W{1'b0}}} - {1'b0, v}) : {1'b0, v};
        n   = 0;
        do begin
            digs[n] = DIGIT_W'(mag % 10);
            mag     = mag / 10;
            n++;
        end while (mag != 0);
        if (v[VAL_W-1]) begin
            c.ch   = ASCII_MINUS;
            c.last = 1'b0;
            pending_text.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--) begin
            c.ch   = ASCII_ZERO + CHAR_W'(digs[i]);
            c.last = (i == 0);
            pending_text.push_back(c);
        end
    endfunction

    // result side: every accepted character against the oldest expectation
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_text.size() == 0) begin
                $error("unexpected character: actual %h last %b", o_character, o_last);
                n_errors++;
            end else begin
                want = pending_text.pop_front();
                if (o_character !== want.ch) begin
                    $error("character: expected %h actual %h", want.ch, o_character);
                    n_errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b actual %b", want.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    // offer one value, holding it until accepted; valid stays high afterwards
    // so back-to-back items need no drop in between
    task automatic send_value(input logic [VAL_W-1:0] v);
        @(negedge i_clk);
        if (tx_idle_pct > 0) begin
            while ($urandom_range(0, 99) < tx_idle_pct) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        format_decimal(v);
    endtask

    // stop offering and wait until every expected character has come out
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_text.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random value with a spread of digit counts and signs
    function automatic logic [VAL_W-1:0] pick_value;
        logic [VAL_W-1:0] v;
        int               p;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: begin
                // short magnitudes so every length shows up often
                v = $urandom >> $urandom_range(1, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
            2: begin
                // around a power of ten, where the digit count changes
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1)) v = -v;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = '0;
                    3: v = '1;
                    default: v = 32'h8000_0000 + $urandom_range(0, 3);
                endcase
            end
        endcase
        return v;
    endfunction

    // extremes, zero, every digit count and sign, and the most negative value
    task automatic test_directed;
        logic [VAL_W-1:0] vals[$];
        vals = '{32'd0, 32'd1, -32'd1, 32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
                 -32'd123, 32'd4567, -32'd98765, 32'd999999, -32'd1000000,
                 32'd12345678, 32'd999999999, 32'd1000000000, -32'd1000000000,
                 32'd1234567890, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA};
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        foreach (vals[i]) send_value(vals[i]);
        drain();
    endtask

    // one random phase at given idle and stall rates
    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        repeat (n) send_value(pick_value());
        drain();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering,
    // so the pipeline fills and the input side must stall
    task automatic test_backpressure;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        @(posedge i_clk);
        hold_left = 300;
        repeat (30) send_value(pick_value());
        drain();
    endtask

    initial begin
        // every input known from time zero
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        i_stall = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(57, 0, 0);
        test_random(57, 60, 0);
        test_random(57, 0, 60);
        test_random(57, 9, 9);
        test_backpressure();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending_text.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### signed_int_to_decimal_ascii_top.f
src/sitoa_pkg.sv
src/signed_int_to_decimal_ascii_top.sv
tb/sv/tb_top.sv
